### design/bmp565_pkg.sv
`timescale 1ns / 1ps

package bmp565_pkg;

  localparam int unsigned HEADER_LEN = 34;
  localparam logic [15:0] BMP_MAGIC  = 16'h4D42;

  localparam logic [15:0] DISPLAY_WIDTH_RESET  = 16'd320;
  localparam logic [15:0] DISPLAY_HEIGHT_RESET = 16'd240;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_HEIGHT = 8'd1;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REASON_MAGIC      = 3'd0,
    REASON_SIZE       = 3'd1,
    REASON_PLANES     = 3'd2,
    REASON_COMPRESSED = 3'd3,
    REASON_OFFSET     = 3'd4
  } reason_t;

  typedef struct packed {
    kind_t       kind;
    reason_t     reject_reason;
    logic [15:0] pixel_rgb565;
  } result_t;

endpackage

### design/bmp565_parser.sv
`timescale 1ns / 1ps

module bmp565_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [7:0]            in_byte,
  input  logic                  in_sof,
  input  logic [15:0]           display_width,
  input  logic [15:0]           display_height,
  output logic                  res_valid,
  output bmp565_pkg::result_t   res
);
  import bmp565_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_SKIP   = 2'd2,
    MODE_PIXELS = 2'd3
  } mode_t;

  mode_t       mode, mode_next, cur_mode;
  logic [31:0] pos, pos_next, cur_pos, pos_inc;
  logic [31:0] data_offset, data_offset_next;
  logic [31:0] image_width, image_width_next;
  logic [31:0] image_height, image_height_next;
  logic [7:0]  magic_lo, magic_lo_next;
  logic        bad_magic, bad_magic_next;
  logic        bad_planes, bad_planes_next;
  logic        bad_comp, bad_comp_next;
  logic [1:0]  phase, phase_next, cur_phase;
  logic [10:0] partial, partial_next;

  logic [5:0]  hdr_pos;
  logic [1:0]  lane;
  logic [31:0] img_max, img_min, disp_max, disp_min;
  logic        size_ok, comp_final;

  // header position is below HEADER_LEN whenever it is used
  assign hdr_pos = cur_pos[5:0];
  assign lane    = hdr_pos[1:0] + 2'd2;
  assign pos_inc = cur_pos + 32'd1;

  always_comb begin
    img_max  = (image_width > image_height) ? image_width : image_height;
    img_min  = (image_width > image_height) ? image_height : image_width;
    disp_max = (display_width > display_height) ? {16'd0, display_width}
                                                : {16'd0, display_height};
    disp_min = (display_width > display_height) ? {16'd0, display_height}
                                                : {16'd0, display_width};
    size_ok  = (img_max == disp_max) && (img_min == disp_min);
  end

  assign comp_final = bad_comp | (in_byte != 8'd0);

  always_comb begin
    cur_mode  = in_sof ? MODE_HEADER : mode;
    cur_pos   = in_sof ? 32'd0 : pos;
    cur_phase = in_sof ? 2'd0 : phase;

    mode_next         = mode;
    pos_next          = pos;
    data_offset_next  = data_offset;
    image_width_next  = image_width;
    image_height_next = image_height;
    magic_lo_next     = magic_lo;
    bad_magic_next    = bad_magic;
    bad_planes_next   = bad_planes;
    bad_comp_next     = bad_comp;
    phase_next        = phase;
    partial_next      = partial;

    res_valid         = 1'b0;
    res.kind          = KIND_PIXEL;
    res.reject_reason = REASON_MAGIC;
    res.pixel_rgb565  = 16'd0;

    if (in_valid) begin
      mode_next  = cur_mode;
      phase_next = cur_phase;
      unique case (cur_mode)
        MODE_IDLE: begin
          mode_next = MODE_IDLE;
        end
        MODE_HEADER: begin
          pos_next = pos_inc;
          // byte lanes are all overwritten before the verdict, so no clear
          if (hdr_pos == 6'd0) begin
            magic_lo_next = in_byte;
          end else if (hdr_pos == 6'd1) begin
            bad_magic_next  = ({in_byte, magic_lo} != BMP_MAGIC);
            bad_planes_next = 1'b0;
            bad_comp_next   = 1'b0;
          end else if (hdr_pos >= 6'd10 && hdr_pos <= 6'd13) begin
            data_offset_next[lane*8 +: 8] = in_byte;
          end else if (hdr_pos >= 6'd18 && hdr_pos <= 6'd21) begin
            image_width_next[lane*8 +: 8] = in_byte;
          end else if (hdr_pos >= 6'd22 && hdr_pos <= 6'd25) begin
            image_height_next[lane*8 +: 8] = in_byte;
          end else if (hdr_pos == 6'd26) begin
            if (in_byte != 8'd1) bad_planes_next = 1'b1;
          end else if (hdr_pos == 6'd27) begin
            if (in_byte != 8'd0) bad_planes_next = 1'b1;
          end else if (hdr_pos >= 6'd30 && hdr_pos <= 6'd33) begin
            bad_comp_next = comp_final;
          end

          if (hdr_pos == 6'(HEADER_LEN - 1)) begin
            res_valid = 1'b1;
            res.kind  = KIND_REJECT;
            mode_next = MODE_IDLE;
            priority if (bad_magic) begin
              res.reject_reason = REASON_MAGIC;
            end else if (!size_ok) begin
              res.reject_reason = REASON_SIZE;
            end else if (bad_planes) begin
              res.reject_reason = REASON_PLANES;
            end else if (comp_final) begin
              res.reject_reason = REASON_COMPRESSED;
            end else if (data_offset < 32'(HEADER_LEN)) begin
              res.reject_reason = REASON_OFFSET;
            end else begin
              res.kind  = KIND_ACCEPT;
              mode_next = (data_offset == 32'(HEADER_LEN)) ? MODE_PIXELS : MODE_SKIP;
            end
          end
        end
        MODE_SKIP: begin
          pos_next = pos_inc;
          if (pos_inc >= data_offset) mode_next = MODE_PIXELS;
        end
        MODE_PIXELS: begin
          unique case (cur_phase)
            2'd0: begin
              partial_next[4:0] = in_byte[7:3];
              phase_next        = 2'd1;
            end
            2'd1: begin
              partial_next[10:5] = in_byte[7:2];
              phase_next         = 2'd2;
            end
            default: begin
              phase_next       = 2'd0;
              res_valid        = 1'b1;
              res.kind         = KIND_PIXEL;
              res.pixel_rgb565 = {in_byte[7:3], partial};
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      pos   <= 32'd0;
      phase <= 2'd0;
    end else begin
      mode  <= mode_next;
      pos   <= pos_next;
      phase <= phase_next;
    end
    data_offset  <= data_offset_next;
    image_width  <= image_width_next;
    image_height <= image_height_next;
    magic_lo     <= magic_lo_next;
    bad_magic    <= bad_magic_next;
    bad_planes   <= bad_planes_next;
    bad_comp     <= bad_comp_next;
    partial      <= partial_next;
  end

endmodule

### design/bmp565_out_buf.sv
`timescale 1ns / 1ps

module bmp565_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bmp565_pkg::result_t push_data,
  output logic                has_room,
  output logic                pop_valid,
  input  logic                pop_ready,
  output bmp565_pkg::result_t pop_data
);
  import bmp565_pkg::*;

  result_t    entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign has_room  = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop       = pop_valid & pop_ready;
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) entry[wr_ptr] <= push_data;
  end

endmodule

### design/bmp_stream_to_rgb565.sv
`timescale 1ns / 1ps

// Decodes a 24-bit BMP byte stream into RGB565 pixels at one byte per clock while the
// output buffer has room. Each beat carries one file byte; tuser high marks byte 0 of
// a file and restarts the parse. After the 34-byte header one verdict beat comes out
// (accepted, or rejected with the first failing check of magic, size, planes,
// compression, offset), then bytes up to the data offset are dropped and every B,G,R
// triple yields one pixel beat. A rejected file is dropped until the next start.
// Every byte is handled in the cycle it is accepted by the parser registers; results
// go through a two-entry output buffer, so the input keeps taking one beat per cycle
// unless both entries wait on the output side. Display size registers are written
// through the cfg channel (index 0 width, 1 height); the user must write them only
// while no file is in flight, as the block does not enforce it.
module bmp_stream_to_rgb565 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic        s_tuser,    // [0] start_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [2:0] reject_reason, [18:3] pixel_rgb565, rest zero
  output logic [1:0]  m_tuser,    // [1:0] kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bmp565_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import bmp565_pkg::*;

  logic [15:0] display_width, display_height;
  logic        in_accept, res_valid, has_room;
  result_t     res, out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_width  <= DISPLAY_WIDTH_RESET;
      display_height <= DISPLAY_HEIGHT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_DISPLAY_WIDTH)  display_width  <= cfg_data;
      if (cfg_index == CFG_DISPLAY_HEIGHT) display_height <= cfg_data;
    end
  end

  assign s_tready  = has_room;
  assign in_accept = s_tvalid & s_tready;

  bmp565_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_accept),
    .in_byte        (s_tdata),
    .in_sof         (s_tuser),
    .display_width  (display_width),
    .display_height (display_height),
    .res_valid      (res_valid),
    .res            (res)
  );

  bmp565_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .has_room  (has_room),
    .pop_valid (m_tvalid),
    .pop_ready (m_tready),
    .pop_data  (out_res)
  );

  assign m_tdata = {5'd0, out_res.pixel_rgb565, out_res.reject_reason};
  assign m_tuser = out_res.kind;

endmodule
